@@ rtl/fpa_pkg.sv @@
// Package with the word sizes, opcodes and pipeline data type of the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned NUM_BITS  = WORD_BITS + FRAC_BITS;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_LT       = 4'd6,
    OP_GT       = 4'd7,
    OP_LE       = 4'd8,
    OP_GE       = 4'd9,
    OP_EQ       = 4'd10,
    OP_NE       = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] result;
    logic                 cmp;
    logic                 dz;
    logic                 neg;
    logic                 is_div;
    logic [WORD_BITS-1:0] rem;
    logic [NUM_BITS-1:0]  num;
    logic [WORD_BITS-1:0] quo;
    logic [WORD_BITS-1:0] dvsr;
  } pipe_t;

endpackage

@@ rtl/fpa_front.sv @@
// Entry stage: computes every non-divide operation and prepares the divider operands.
`timescale 1ns / 1ps
module fpa_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [3:0]                     opcode_i,
  input  logic [fpa_pkg::WORD_BITS-1:0]  a_i,
  input  logic [fpa_pkg::WORD_BITS-1:0]  b_i,
  input  logic                           hold_i,
  output logic                           stall_o,
  output logic                           valid_o,
  output fpa_pkg::pipe_t                 data_o
);

  localparam int unsigned W = fpa_pkg::WORD_BITS;
  localparam int unsigned F = fpa_pkg::FRAC_BITS;

  logic                  valid_q;
  fpa_pkg::pipe_t        data_q;
  fpa_pkg::pipe_t        data_d;
  fpa_pkg::op_e          op;
  logic signed [2*W-1:0] prod;
  logic                  lt_ab;
  logic                  lt_ba;
  logic [W-1:0]          mag_a;
  logic [W-1:0]          mag_b;

  assign op      = fpa_pkg::op_e'(opcode_i);
  assign prod    = $signed(a_i) * $signed(b_i);
  assign lt_ab   = $signed(a_i) < $signed(b_i);
  assign lt_ba   = $signed(b_i) < $signed(a_i);
  assign mag_a   = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mag_b   = b_i[W-1] ? (~b_i + W'(1)) : b_i;
  assign stall_o = !rst_ni | (valid_q & hold_i);
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d        = '0;
    data_d.neg    = a_i[W-1] ^ b_i[W-1];
    data_d.dz     = (op == fpa_pkg::OP_DIV) && (b_i == '0);
    data_d.is_div = (op == fpa_pkg::OP_DIV);
    data_d.num    = {mag_a, F'(0)};
    data_d.dvsr   = mag_b;
    case (op)
      fpa_pkg::OP_ADD:      data_d.result = a_i + b_i;
      fpa_pkg::OP_SUB:      data_d.result = a_i - b_i;
      fpa_pkg::OP_MUL:      data_d.result = prod[F+W-1:F];
      fpa_pkg::OP_DIV:      data_d.result = '0;
      fpa_pkg::OP_MIN:      data_d.result = lt_ab ? a_i : b_i;
      fpa_pkg::OP_MAX:      data_d.result = lt_ba ? a_i : b_i;
      fpa_pkg::OP_LT:       data_d.cmp = lt_ab;
      fpa_pkg::OP_GT:       data_d.cmp = lt_ba;
      fpa_pkg::OP_LE:       data_d.cmp = !lt_ba;
      fpa_pkg::OP_GE:       data_d.cmp = !lt_ab;
      fpa_pkg::OP_EQ:       data_d.cmp = (a_i == b_i);
      fpa_pkg::OP_NE:       data_d.cmp = (a_i != b_i);
      fpa_pkg::OP_INC:      data_d.result = a_i + W'(1);
      fpa_pkg::OP_DEC:      data_d.result = a_i - W'(1);
      fpa_pkg::OP_FROM_INT: data_d.result = a_i << F;
      fpa_pkg::OP_TO_INT:   data_d.result = W'($signed(a_i) >>> F);
      default:              data_d.result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      data_q <= data_d;
    end
  end

endmodule

@@ rtl/fpa_div_cell.sv @@
// One divider cell: a restoring step that yields one quotient bit per request.
`timescale 1ns / 1ps
module fpa_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  fpa_pkg::pipe_t data_i,
  input  logic           hold_i,
  output logic           stall_o,
  output logic           valid_o,
  output fpa_pkg::pipe_t data_o
);

  localparam int unsigned W = fpa_pkg::WORD_BITS;
  localparam int unsigned N = fpa_pkg::NUM_BITS;

  logic           valid_q;
  fpa_pkg::pipe_t data_q;
  fpa_pkg::pipe_t data_d;
  logic [W:0]     trial;
  logic [W:0]     diff;
  logic           ge;

  assign trial   = {data_i.rem, data_i.num[N-1]};
  assign diff    = trial - {1'b0, data_i.dvsr};
  assign ge      = !diff[W];
  assign stall_o = valid_q & hold_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d     = data_i;
    data_d.rem = ge ? diff[W-1:0] : trial[W-1:0];
    data_d.num = {data_i.num[N-2:0], 1'b0};
    data_d.quo = {data_i.quo[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      data_q <= data_d;
    end
  end

endmodule

@@ rtl/fpa_back.sv @@
// Output stage: applies the quotient sign and holds the result until it is taken.
`timescale 1ns / 1ps
module fpa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  fpa_pkg::pipe_t                data_i,
  input  logic                          stall_i,
  output logic                          stall_o,
  output logic                          valid_o,
  output logic [fpa_pkg::WORD_BITS-1:0] result_o,
  output logic                          cmp_o,
  output logic                          dz_o
);

  localparam int unsigned W = fpa_pkg::WORD_BITS;

  logic         valid_q;
  logic [W-1:0] result_q;
  logic [W-1:0] result_d;
  logic         cmp_q;
  logic         dz_q;

  assign stall_o  = valid_q & stall_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign cmp_o    = cmp_q;
  assign dz_o     = dz_q;

  always_comb begin
    if (!data_i.is_div) begin
      result_d = data_i.result;
    end else if (data_i.dz) begin
      result_d = '0;
    end else if (data_i.neg) begin
      result_d = ~data_i.quo + W'(1);
    end else begin
      result_d = data_i.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      result_q <= result_d;
      cmp_q    <= data_i.cmp;
      dz_q     <= data_i.dz;
    end
  end

endmodule

@@ rtl/fixed_point_alu_unit.sv @@
// Stages from request to result: entry stage, 40 divider cells, output stage.
// One request per cycle unless stalled; each cell retires and passes on a quotient bit.
// Every opcode travels the full cell chain, so results leave in request order.
// A stalled stage holds its request while empty stages upstream keep filling.
// Reset clears all valid flags at once; no request is accepted during reset.
`timescale 1ns / 1ps
module fixed_point_alu_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [3:0]                    opcode_i,
  input  logic [fpa_pkg::WORD_BITS-1:0] operand_a_i,
  input  logic [fpa_pkg::WORD_BITS-1:0] operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fpa_pkg::WORD_BITS-1:0] result_o,
  output logic                          compare_true_o,
  output logic                          divide_by_zero_o
);

  localparam int unsigned N = fpa_pkg::NUM_BITS;

  logic           valid_c [N+1];
  logic           stall_c [N+1];
  fpa_pkg::pipe_t data_c  [N+1];

  fpa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .opcode_i (opcode_i),
    .a_i      (operand_a_i),
    .b_i      (operand_b_i),
    .hold_i   (stall_c[0]),
    .stall_o  (in_stall_o),
    .valid_o  (valid_c[0]),
    .data_o   (data_c[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    fpa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .data_i  (data_c[k]),
      .hold_i  (stall_c[k+1]),
      .stall_o (stall_c[k]),
      .valid_o (valid_c[k+1]),
      .data_o  (data_c[k+1])
    );
  end

  fpa_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_c[N]),
    .data_i   (data_c[N]),
    .stall_i  (out_stall_i),
    .stall_o  (stall_c[N]),
    .valid_o  (out_valid_o),
    .result_o (result_o),
    .cmp_o    (compare_true_o),
    .dz_o     (divide_by_zero_o)
  );

endmodule

@@ tb/alu_checker.sv @@
// Checker for the fixed-point ALU: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module alu_checker (
  input  logic                          clk_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [3:0]                    opcode_i,
  input  logic [fpa_pkg::WORD_BITS-1:0] operand_a_i,
  input  logic [fpa_pkg::WORD_BITS-1:0] operand_b_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [fpa_pkg::WORD_BITS-1:0] result_i,
  input  logic                          compare_true_i,
  input  logic                          divide_by_zero_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o,
  output int                            checked_count_o
);

  localparam int unsigned WordBits = fpa_pkg::WORD_BITS;
  localparam int unsigned FracBits = fpa_pkg::FRAC_BITS;

  typedef struct packed {
    logic [WordBits-1:0] result;
    logic                compare_true;
    logic                divide_by_zero;
  } alu_result_t;

  alu_result_t expected_results[$];
  int          mismatches = 0;
  int          outstanding = 0;
  int          checked = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;
  assign checked_count_o  = checked;

  function automatic alu_result_t predict_alu_result(fpa_pkg::op_e op, logic [WordBits-1:0] a,
                                                     logic [WordBits-1:0] b);
    logic signed [63:0] a_wide;
    logic signed [63:0] b_wide;
    logic signed [63:0] product;
    logic        [63:0] mag_a;
    logic        [63:0] mag_b;
    logic        [63:0] quotient;
    alu_result_t        r;
    a_wide = {{(64-WordBits){a[WordBits-1]}}, a};
    b_wide = {{(64-WordBits){b[WordBits-1]}}, b};
    mag_a  = a_wide[63] ? -a_wide : a_wide;
    mag_b  = b_wide[63] ? -b_wide : b_wide;
    r      = '0;
    case (op)
      fpa_pkg::OP_ADD: r.result = a + b;
      fpa_pkg::OP_SUB: r.result = a - b;
      fpa_pkg::OP_MUL: begin
        product  = a_wide * b_wide;
        r.result = product[WordBits+FracBits-1:FracBits];
      end
      fpa_pkg::OP_DIV: begin
        if (b == '0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          quotient = (mag_a << FracBits) / mag_b;
          if (a[WordBits-1] != b[WordBits-1]) quotient = -quotient;
          r.result = quotient[WordBits-1:0];
        end
      end
      fpa_pkg::OP_MIN: r.result = ($signed(a) < $signed(b)) ? a : b;
      fpa_pkg::OP_MAX: r.result = ($signed(b) < $signed(a)) ? a : b;
      fpa_pkg::OP_LT: r.compare_true = $signed(a) < $signed(b);
      fpa_pkg::OP_GT: r.compare_true = $signed(b) < $signed(a);
      fpa_pkg::OP_LE: r.compare_true = !($signed(b) < $signed(a));
      fpa_pkg::OP_GE: r.compare_true = !($signed(a) < $signed(b));
      fpa_pkg::OP_EQ: r.compare_true = (a == b);
      fpa_pkg::OP_NE: r.compare_true = (a != b);
      fpa_pkg::OP_INC: r.result = a + WordBits'(1);
      fpa_pkg::OP_DEC: r.result = a - WordBits'(1);
      fpa_pkg::OP_FROM_INT: r.result = a << FracBits;
      fpa_pkg::OP_TO_INT: begin
        product  = a_wide >>> FracBits;
        r.result = product[WordBits-1:0];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WordBits-1:0] got,
                                 logic [WordBits-1:0] want);
    $display("MISMATCH at %0t: %s got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    alu_result_t want;
    logic        in_fire;
    logic        out_fire;
    in_fire  = in_valid_i && !in_stall_i;
    out_fire = out_valid_i && !out_stall_i;
    if (in_fire) begin
      expected_results.push_back(predict_alu_result(fpa_pkg::op_e'(opcode_i), operand_a_i,
                                                    operand_b_i));
    end
    if (out_fire) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", result_i, '0);
      end else begin
        want = expected_results.pop_front();
        if (result_i !== want.result) report_mismatch("result", result_i, want.result);
        if (compare_true_i !== want.compare_true) begin
          report_mismatch("compare_true", WordBits'(compare_true_i),
                          WordBits'(want.compare_true));
        end
        if (divide_by_zero_i !== want.divide_by_zero) begin
          report_mismatch("divide_by_zero", WordBits'(divide_by_zero_i),
                          WordBits'(want.divide_by_zero));
        end
        checked <= checked + 1;
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the fixed-point ALU testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned WordBits = fpa_pkg::WORD_BITS;
  localparam int unsigned FracBits = fpa_pkg::FRAC_BITS;
  localparam int IdleLimit    = 1000;
  localparam int DrainCycles  = 60;
  localparam int RandomItems  = 900;
  localparam logic [WordBits-1:0] MaxWord = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] MinWord = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic [WordBits-1:0] AllOnes = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [3:0]          opcode = '0;
  logic [WordBits-1:0] operand_a = '0;
  logic [WordBits-1:0] operand_b = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WordBits-1:0] result;
  logic                compare_true;
  logic                divide_by_zero;

  int   mismatch_count;
  int   outstanding;
  int   checked_count;
  int   sent_count = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  logic quiet = 1'b0;

  always #1 clk_i = ~clk_i;

  fixed_point_alu_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .operand_a_i     (operand_a),
    .operand_b_i     (operand_b),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_o        (result),
    .compare_true_o  (compare_true),
    .divide_by_zero_o(divide_by_zero)
  );

  alu_checker u_checker (
    .clk_i           (clk_i),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .operand_a_i     (operand_a),
    .operand_b_i     (operand_b),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .result_i        (result),
    .compare_true_i  (compare_true),
    .divide_by_zero_i(divide_by_zero),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding),
    .checked_count_o (checked_count)
  );

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("Timeout: no request or result moved for %0d cycles.", IdleLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin : result_stall
    int pick;
    pick = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (pick < 60) begin
      out_stall <= 1'b0;
    end else if (pick < 93) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(10, 50);
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WordBits-1:0] pick_operand();
    logic signed [WordBits-1:0] value;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = $urandom();
      4, 5: value = $signed($urandom_range(0, 4095)) - 2048;
      6: begin
        case ($urandom_range(0, 6))
          0: value = '0;
          1: value = 1;
          2: value = AllOnes;
          3: value = MaxWord;
          4: value = MinWord;
          5: value = 1 << FracBits;
          default: value = -(1 << FracBits);
        endcase
      end
      7: begin
        value = $urandom_range(0, 255) << $urandom_range(0, 23);
        if ($urandom_range(0, 1) == 1) value = -value;
      end
      default: value = $urandom();
    endcase
    return value;
  endfunction

  task automatic push_request(fpa_pkg::op_e op, logic [WordBits-1:0] a,
                              logic [WordBits-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk_i); while (in_stall);
    sent_count++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: wrap-around, overflow, division by zero, ties and sign handling.
    push_request(fpa_pkg::OP_ADD, MaxWord, 1);
    push_request(fpa_pkg::OP_SUB, MinWord, 1);
    push_request(fpa_pkg::OP_MUL, MaxWord, MaxWord);
    push_request(fpa_pkg::OP_MUL, MinWord, MinWord);
    push_request(fpa_pkg::OP_MUL, 32'hFFFF_FE80, 32'h0000_0280);
    push_request(fpa_pkg::OP_DIV, 32'h0000_1234, '0);
    push_request(fpa_pkg::OP_DIV, MinWord, AllOnes);
    push_request(fpa_pkg::OP_DIV, 32'hFFFF_FD00, 32'h0000_0200);
    push_request(fpa_pkg::OP_DIV, 1, MinWord);
    push_request(fpa_pkg::OP_MIN, 32'h0000_0500, 32'h0000_0500);
    push_request(fpa_pkg::OP_MAX, MinWord, MaxWord);
    push_request(fpa_pkg::OP_LT, MinWord, MaxWord);
    push_request(fpa_pkg::OP_GT, MinWord, MaxWord);
    push_request(fpa_pkg::OP_LE, 32'h0000_0100, 32'h0000_0100);
    push_request(fpa_pkg::OP_GE, AllOnes, '0);
    push_request(fpa_pkg::OP_EQ, AllOnes, AllOnes);
    push_request(fpa_pkg::OP_NE, '0, MinWord);
    push_request(fpa_pkg::OP_INC, MaxWord, AllOnes);
    push_request(fpa_pkg::OP_DEC, MinWord, '0);
    push_request(fpa_pkg::OP_FROM_INT, MinWord, '0);
    push_request(fpa_pkg::OP_FROM_INT, 32'h00FF_FFFF, AllOnes);
    push_request(fpa_pkg::OP_TO_INT, AllOnes, '0);
    push_request(fpa_pkg::OP_TO_INT, MinWord, '0);
    push_request(fpa_pkg::OP_TO_INT, MaxWord, '0);

    for (int phase = 0; phase < 4; phase++) begin
      quiet <= (phase == 2);
      for (int n = 0; n < RandomItems / 4; n++) begin
        a = pick_operand();
        b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
        push_request(fpa_pkg::op_e'($urandom_range(0, 15)), a, b);
      end
      // After the second phase the sender holds off until the pipeline has handed back every result.
      if (phase == 1) wait_until_drained();
    end

    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d requests across all sixteen opcodes with random gaps and stalls.",
             sent_count);
    $display("Compared %0d results; %0d mismatches found.", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
